FILE: design/irpd_pkg.sv
// ---------------------------------------------------------------------------
// irpd_pkg: shared types and constants of the pulse-distance IR decoder
// Event codes, register indexes, configuration and result word layouts.
// ---------------------------------------------------------------------------
`default_nettype none

package irpd_pkg;

    // widths fixed by the register map and the result word
    localparam int LIMIT_W = 12;
    localparam int BITS_W  = 8;
    localparam int CODE_W  = 2;
    localparam int INDEX_W = 3;

    // event codes
    localparam logic [CODE_W-1:0] EV_ZERO = 2'd0;
    localparam logic [CODE_W-1:0] EV_ONE  = 2'd1;
    localparam logic [CODE_W-1:0] EV_END  = 2'd2;
    localparam logic [CODE_W-1:0] EV_RERR = 2'd3;

    // register indexes
    localparam logic [INDEX_W-1:0] REG_READER_MARK  = 3'd0;
    localparam logic [INDEX_W-1:0] REG_READER_SPACE = 3'd1;
    localparam logic [INDEX_W-1:0] REG_SPACE_TMO    = 3'd2;
    localparam logic [INDEX_W-1:0] REG_ONE_THRESH   = 3'd3;
    localparam logic [INDEX_W-1:0] REG_MAX_BITS     = 3'd4;

    // register reset values
    localparam logic [LIMIT_W-1:0] RST_READER_MARK  = 12'd800;
    localparam logic [LIMIT_W-1:0] RST_READER_SPACE = 12'd500;
    localparam logic [LIMIT_W-1:0] RST_SPACE_TMO    = 12'd300;
    localparam logic [LIMIT_W-1:0] RST_ONE_THRESH   = 12'd100;
    localparam logic [BITS_W-1:0]  RST_MAX_BITS     = 8'd48;

    // configuration as seen by the decoder
    typedef struct packed {
        logic [LIMIT_W-1:0] reader_mark_limit;
        logic [LIMIT_W-1:0] reader_space_limit;
        logic [LIMIT_W-1:0] space_timeout;
        logic [LIMIT_W-1:0] one_threshold;
        logic [BITS_W-1:0]  max_bits;
    } t_cfg;

    // one decoded event
    typedef struct packed {
        logic [CODE_W-1:0] event_code;
        logic [BITS_W-1:0] bit_index;
        logic              frame_last;
    } t_result;

endpackage

`default_nettype wire

FILE: design/irpd_cfg.sv
// ---------------------------------------------------------------------------
// irpd_cfg: configuration registers
// Holds the timing limits and the frame length, written by index.
// ---------------------------------------------------------------------------
`default_nettype none

module irpd_cfg
    import irpd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [INDEX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0] i_cfg_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;

    // register file, writes beyond the map are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reader_mark_limit  <= RST_READER_MARK;
            r_cfg.reader_space_limit <= RST_READER_SPACE;
            r_cfg.space_timeout      <= RST_SPACE_TMO;
            r_cfg.one_threshold      <= RST_ONE_THRESH;
            r_cfg.max_bits           <= RST_MAX_BITS;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_READER_MARK:  r_cfg.reader_mark_limit  <= i_cfg_data;
                REG_READER_SPACE: r_cfg.reader_space_limit <= i_cfg_data;
                REG_SPACE_TMO:    r_cfg.space_timeout      <= i_cfg_data;
                REG_ONE_THRESH:   r_cfg.one_threshold      <= i_cfg_data;
                REG_MAX_BITS:     r_cfg.max_bits           <= i_cfg_data[BITS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: design/irpd_core.sv
// ---------------------------------------------------------------------------
// irpd_core: sample register and frame state machine
// Registers one line sample, then measures marks and spaces and decides
// bits, reader errors and frame ends in one pass.
// ---------------------------------------------------------------------------
`default_nettype none

module irpd_core
    import irpd_pkg::*;
#(
    parameter int COUNT_WIDTH = 12
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire logic i_level,
    output logic      o_stall,
    input  t_cfg      i_cfg,
    input  wire logic i_full,
    output logic      o_res_valid,
    output t_result   o_res
);

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RMARK,
        PH_RSPACE,
        PH_DMARK,
        PH_DSPACE
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick;
    logic [BITS_W-1:0]      r_bits, n_bits;
    logic                   r_in_valid;
    logic                   r_level;

    logic                   adv;
    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [CMP_W-1:0]       tick_x, inc_x;
    logic [CMP_W-1:0]       rml_x, rsl_x, tmo_x, thr_x;
    logic [BITS_W-1:0]      limit_bits;
    logic                   frame_full;
    logic                   n_res_valid;
    t_result                n_res;

    // advance the sample when the result buffer has room
    assign adv     = r_in_valid && !i_full;
    assign o_stall = r_in_valid && i_full;

    // saturating tick count and widened compare operands
    assign tick_inc   = (r_tick == CNT_MAX) ? r_tick : r_tick + CNT_ONE;
    assign tick_x     = CMP_W'(r_tick);
    assign inc_x      = CMP_W'(tick_inc);
    assign rml_x      = CMP_W'(i_cfg.reader_mark_limit);
    assign rsl_x      = CMP_W'(i_cfg.reader_space_limit);
    assign tmo_x      = CMP_W'(i_cfg.space_timeout);
    assign thr_x      = CMP_W'(i_cfg.one_threshold);
    assign limit_bits = (i_cfg.max_bits == '0) ? BITS_W'(1) : i_cfg.max_bits;
    assign frame_full = ({1'b0, r_bits} + 9'd1) >= {1'b0, limit_bits};

    // frame state machine step
    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bits      = r_bits;
        n_res_valid = 1'b0;
        n_res       = '{event_code: EV_RERR, bit_index: r_bits, frame_last: 1'b1};
        case (r_phase)
            PH_RMARK: begin
                if (!r_level) begin
                    n_tick = tick_inc;
                end else if (tick_x > rml_x || i_cfg.reader_space_limit == '0) begin
                    n_phase     = PH_IDLE;
                    n_tick      = '0;
                    n_res_valid = 1'b1;
                end else begin
                    n_phase = PH_RSPACE;
                    n_tick  = CNT_ONE;
                end
            end
            PH_RSPACE: begin
                if (!r_level) begin
                    n_phase = PH_DMARK;
                    n_tick  = CNT_ONE;
                end else if (inc_x > rsl_x) begin
                    n_phase     = PH_IDLE;
                    n_tick      = '0;
                    n_res_valid = 1'b1;
                end else begin
                    n_tick = tick_inc;
                end
            end
            PH_DMARK: begin
                if (!r_level) begin
                    n_tick = tick_inc;
                end else if (i_cfg.space_timeout == '0) begin
                    n_phase              = PH_IDLE;
                    n_tick               = '0;
                    n_res_valid          = 1'b1;
                    n_res.event_code     = EV_END;
                end else begin
                    n_phase = PH_DSPACE;
                    n_tick  = CNT_ONE;
                end
            end
            PH_DSPACE: begin
                if (r_level) begin
                    if (inc_x > tmo_x) begin
                        n_phase          = PH_IDLE;
                        n_tick           = '0;
                        n_res_valid      = 1'b1;
                        n_res.event_code = EV_END;
                    end else begin
                        n_tick = tick_inc;
                    end
                end else begin
                    // space ended: decide the bit
                    n_res_valid      = 1'b1;
                    n_res.event_code = (tick_x < thr_x) ? EV_ZERO : EV_ONE;
                    n_res.frame_last = frame_full;
                    n_tick           = CNT_ONE;
                    if (frame_full) begin
                        n_phase = PH_RMARK;
                        n_bits  = '0;
                    end else begin
                        n_phase = PH_DMARK;
                        n_bits  = r_bits + BITS_W'(1);
                    end
                end
            end
            default: begin
                if (!r_level) begin
                    n_phase = PH_RMARK;
                    n_tick  = CNT_ONE;
                    n_bits  = '0;
                end else begin
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                end
            end
        endcase
    end

    // sample register and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_tick     <= '0;
            r_bits     <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_phase <= n_phase;
                r_tick  <= n_tick;
                r_bits  <= n_bits;
            end
        end
    end

    // sample payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_level <= i_level;
        end
    end

    assign o_res_valid = adv && n_res_valid;
    assign o_res       = n_res;

    // idle always holds a cleared count, any other phase a running one
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_tick == '0))
        else $error("idle phase with nonzero tick count");
    a_busy_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_tick != '0))
        else $error("active phase with zero tick count");
    // a frame-closing event leaves the machine idle or in a fresh reader
    a_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.frame_last) |=>
        ((r_phase == PH_IDLE) || (r_phase == PH_RMARK && r_bits == '0)))
        else $error("frame close did not restart the machine");
    // bit count inside a frame never reaches the wrap value
    a_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DMARK || r_phase == PH_DSPACE) |->
        (r_bits != '1))
        else $error("bit count ran past the frame length");

endmodule

`default_nettype wire

FILE: design/irpd_outq.sv
// ---------------------------------------------------------------------------
// irpd_outq: two-entry result buffer
// Output register plus skid slot so the decoder keeps going while a
// finished word waits downstream.
// ---------------------------------------------------------------------------
`default_nettype none

module irpd_outq
    import irpd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_result   i_data,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_result   o_data
);

    logic [1:0] r_count, n_count;
    t_result    r_head, r_skid;
    logic       pop;

    assign pop     = (r_count != 2'd0) && !i_stall;
    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_head;
    assign n_count = r_count + {1'b0, i_push} - {1'b0, pop};

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // slot payloads
    always_ff @(posedge i_clk) begin
        case (r_count)
            2'd0: begin
                if (i_push) begin
                    r_head <= i_data;
                end
            end
            2'd1: begin
                if (i_push && pop) begin
                    r_head <= i_data;
                end else if (i_push) begin
                    r_skid <= i_data;
                end
            end
            default: begin
                if (pop) begin
                    r_head <= r_skid;
                end
            end
        endcase
    end

    // no push into a full buffer, count never exceeds two
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full result buffer");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd3))
        else $error("result buffer count out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(r_head)))
        else $error("stalled result word changed");

endmodule

`default_nettype wire

FILE: design/ir_pulse_distance_decoder.sv
// ---------------------------------------------------------------------------
// ir_pulse_distance_decoder: pulse-distance IR frame decoder
// Samples an active-low receiver line, checks the reader, decodes data
// bits by space length and reports frame end and reader errors.
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  input   | i_in_valid/o_in_stall  | i_ir_level
//  output  | o_out_valid/i_out_stall| o_event_code, o_bit_index, o_frame_last
//  config  | i_cfg_we               | i_cfg_index, i_cfg_data
//
//  One sample word is taken every cycle unless the input is stalled; a result
//  word passes through the sample register, then the result buffer.
//  Most samples give no result; the line state machine is a single pass.
//  Reset clears the state to idle and loads the register defaults.
//  The two-entry result buffer absorbs output stalls; input stalls only
//  when it is full and a sample is waiting.
// ---------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_decoder
    import irpd_pkg::*;
#(
    parameter int COUNT_WIDTH = 12
)(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic               i_ir_level,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [CODE_W-1:0]       o_event_code,
    output logic [BITS_W-1:0]       o_bit_index,
    output logic                    o_frame_last,
    input  wire logic               i_cfg_we,
    input  wire logic [INDEX_W-1:0] i_cfg_index,
    input  wire logic [LIMIT_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_result res, out_word;
    logic    res_valid;
    logic    q_full;

    // configuration registers
    irpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // decoder pass
    irpd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_level     (i_ir_level),
        .o_stall     (o_in_stall),
        .i_cfg       (cfg),
        .i_full      (q_full),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result buffer
    irpd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (q_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_word)
    );

    assign o_event_code = out_word.event_code;
    assign o_bit_index  = out_word.bit_index;
    assign o_frame_last = out_word.frame_last;

endmodule

`default_nettype wire

FILE: dv/ir_pulse_distance_decoder_tb.sv
// ---------------------------------------------------------------------------
// ir_pulse_distance_decoder_tb: self-checking bench of the IR frame decoder
// Streams receiver line samples through the valid/stall channel, runs a
// line decoder of its own next to the block and compares every event word
// field by field. A short table of directed runs comes first, then phases of
// random frames under changing register settings, with random idling on
// both sides, one long output hold-off and a drain between phases.
// ---------------------------------------------------------------------------
`default_nettype none

module ir_pulse_distance_decoder_tb;
    import irpd_pkg::*;

    localparam int CNT_W = 12;

    // line decoder phases
    typedef enum logic [2:0] {
        LN_IDLE,
        LN_RMARK,
        LN_RSPACE,
        LN_DMARK,
        LN_DSPACE
    } t_line_phase;

    // one row of the directed table
    typedef struct {
        bit                 is_cfg;
        logic [INDEX_W-1:0] reg_idx;
        logic [LIMIT_W-1:0] value;
        logic               lvl;
        int                 len;
        bit                 pinned;
        t_result            ev;
    } t_run;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_ir_level = 1'b1;
    logic i_out_stall = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [INDEX_W-1:0] i_cfg_index = '0;
    logic [LIMIT_W-1:0] i_cfg_data = '0;
    logic o_in_stall;
    logic o_out_valid;
    logic [CODE_W-1:0] o_event_code;
    logic [BITS_W-1:0] o_bit_index;
    logic o_frame_last;

    // decoder copy kept by the bench
    t_cfg line_cfg;
    t_line_phase line_ph;
    logic [CNT_W-1:0] line_ticks;
    logic [BITS_W-1:0] line_bits;

    t_result event_q[$];
    t_run plan[$];
    int n_sent = 0;
    int n_events = 0;
    int fails = 0;
    bit calm = 1'b0;
    int hold_asks = 0;
    int hold_done = 0;
    int hold_left = 0;

    ir_pulse_distance_decoder #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_ir_level(i_ir_level),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_event_code(o_event_code),
        .o_bit_index(o_bit_index),
        .o_frame_last(o_frame_last),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_result make_ev(input logic [CODE_W-1:0] code,
                                        input logic [BITS_W-1:0] idx, input logic last);
        t_result r;
        r.event_code = code;
        r.bit_index = idx;
        r.frame_last = last;
        return r;
    endfunction

    function automatic void count_tick();
        if (line_ticks != '1)
            line_ticks = line_ticks + CNT_W'(1);
    endfunction

    function automatic void line_idle();
        line_ph = LN_IDLE;
        line_ticks = '0;
    endfunction

    // one line sample into the decoder copy, returns 1 with an event
    function automatic bit decode_sample(input logic lvl, output t_result ev);
        int lim_bits;
        logic [BITS_W-1:0] idx;
        logic [CODE_W-1:0] code;
        ev = '0;
        lim_bits = (line_cfg.max_bits == '0) ? 1 : int'(line_cfg.max_bits);
        case (line_ph)
            LN_RMARK: begin
                if (!lvl) begin
                    count_tick();
                    return 1'b0;
                end
                if (line_ticks > line_cfg.reader_mark_limit) begin
                    line_idle();
                    ev = make_ev(EV_RERR, line_bits, 1'b1);
                    return 1'b1;
                end
                line_ph = LN_RSPACE;
                line_ticks = CNT_W'(1);
                if (line_ticks > line_cfg.reader_space_limit) begin
                    line_idle();
                    ev = make_ev(EV_RERR, line_bits, 1'b1);
                    return 1'b1;
                end
                return 1'b0;
            end
            LN_RSPACE: begin
                if (!lvl) begin
                    line_ph = LN_DMARK;
                    line_ticks = CNT_W'(1);
                    return 1'b0;
                end
                count_tick();
                if (line_ticks > line_cfg.reader_space_limit) begin
                    line_idle();
                    ev = make_ev(EV_RERR, line_bits, 1'b1);
                    return 1'b1;
                end
                return 1'b0;
            end
            LN_DMARK: begin
                if (!lvl) begin
                    count_tick();
                    return 1'b0;
                end
                line_ph = LN_DSPACE;
                line_ticks = CNT_W'(1);
                if (line_ticks > line_cfg.space_timeout) begin
                    line_idle();
                    ev = make_ev(EV_END, line_bits, 1'b1);
                    return 1'b1;
                end
                return 1'b0;
            end
            LN_DSPACE: begin
                if (lvl) begin
                    count_tick();
                    if (line_ticks > line_cfg.space_timeout) begin
                        line_idle();
                        ev = make_ev(EV_END, line_bits, 1'b1);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                // space ends on the first mark sample: decide the bit
                code = (line_ticks < line_cfg.one_threshold) ? EV_ZERO : EV_ONE;
                idx = line_bits;
                line_bits = line_bits + BITS_W'(1);
                if (int'(idx) + 1 >= lim_bits) begin
                    // frame full, this mark opens a new reader
                    line_ph = LN_RMARK;
                    line_ticks = CNT_W'(1);
                    line_bits = '0;
                    ev = make_ev(code, idx, 1'b1);
                    return 1'b1;
                end
                line_ph = LN_DMARK;
                line_ticks = CNT_W'(1);
                ev = make_ev(code, idx, 1'b0);
                return 1'b1;
            end
            default: begin
                if (!lvl) begin
                    line_ph = LN_RMARK;
                    line_ticks = CNT_W'(1);
                    line_bits = '0;
                end else begin
                    line_idle();
                end
                return 1'b0;
            end
        endcase
    endfunction

    // directed table rows
    function automatic void add_run(input logic lvl, input int len);
        t_run r;
        r = '{default: 0};
        r.lvl = lvl;
        r.len = len;
        plan.push_back(r);
    endfunction

    function automatic void add_hit(input logic lvl, input int len, input logic [CODE_W-1:0] code,
                                    input logic [BITS_W-1:0] idx, input logic last);
        t_run r;
        r = '{default: 0};
        r.lvl = lvl;
        r.len = len;
        r.pinned = 1'b1;
        r.ev = make_ev(code, idx, last);
        plan.push_back(r);
    endfunction

    function automatic void add_reg(input logic [INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        t_run r;
        r = '{default: 0};
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.value = val;
        plan.push_back(r);
    endfunction

    // offer one sample word, predict once it is taken
    task automatic send_sample(input logic lvl, input bit pinned, input t_result pinned_ev);
        t_result ev;
        bit got;
        while (!calm && $urandom_range(0, 99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ir_level <= lvl;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        n_sent++;
        got = decode_sample(lvl, ev);
        if (pinned) begin
            event_q.push_back(pinned_ev);
            n_events++;
        end else if (got) begin
            event_q.push_back(ev);
            n_events++;
        end
    endtask

    task automatic send_run(input logic lvl, input int len);
        repeat (len) send_sample(lvl, 1'b0, '0);
    endtask

    // let every pending event out, then cover the pipeline latency
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (event_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_READER_MARK:  line_cfg.reader_mark_limit = val;
            REG_READER_SPACE: line_cfg.reader_space_limit = val;
            REG_SPACE_TMO:    line_cfg.space_timeout = val;
            REG_ONE_THRESH:   line_cfg.one_threshold = val;
            REG_MAX_BITS:     line_cfg.max_bits = val[BITS_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic load_settings(input t_cfg c);
        wait_drain();
        write_reg(REG_READER_MARK, c.reader_mark_limit);
        write_reg(REG_READER_SPACE, c.reader_space_limit);
        write_reg(REG_SPACE_TMO, c.space_timeout);
        write_reg(REG_ONE_THRESH, c.one_threshold);
        write_reg(REG_MAX_BITS, LIMIT_W'(c.max_bits));
    endtask

    // reader length: mostly within the limit, sometimes just past it
    function automatic int reader_len(input int lim);
        if (lim == 0)
            return $urandom_range(1, 3);
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, lim);
        return lim + $urandom_range(1, 3);
    endfunction

    // data space length around the one threshold, inside the timeout but for a rare overrun
    function automatic int space_len();
        int thr;
        int tmo;
        int s;
        thr = int'(line_cfg.one_threshold);
        tmo = int'(line_cfg.space_timeout);
        if (tmo == 0)
            return 1;
        if ($urandom_range(0, 99) < 5)
            return tmo + 1;
        case ($urandom_range(0, 3))
            0: s = thr - 1;
            1: s = thr;
            default: s = $urandom_range(1, (tmo > 40) ? 40 : tmo);
        endcase
        if (s < 1)
            s = 1;
        if (s > tmo)
            s = tmo;
        return s;
    endfunction

    // one frame: reader, data bits, closing mark and trailer, or line noise
    task automatic send_frame(input int lo_bits, input int hi_bits);
        int nb;
        if (lo_bits == 0 && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 30)) send_sample(1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
            send_run(1'b1, $urandom_range(1, 3));
            send_run(1'b0, reader_len(int'(line_cfg.reader_mark_limit)));
            send_run(1'b1, reader_len(int'(line_cfg.reader_space_limit)));
            nb = $urandom_range(lo_bits, hi_bits);
            repeat (nb) begin
                send_run(1'b0, $urandom_range(1, 4));
                send_run(1'b1, space_len());
            end
            send_run(1'b0, $urandom_range(1, 4));
            send_run(1'b1, int'(line_cfg.space_timeout) + $urandom_range(1, 3));
        end
    endtask

    // output side: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_done != hold_asks) begin
            hold_done <= hold_asks;
            hold_left <= 400;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < 34);
        end
    end

    // compare each accepted event word with the oldest prediction
    always @(posedge i_clk) begin : check_words
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (event_q.size() == 0) begin
                $error("unexpected word: event_code %0d bit_index %0d frame_last %0d",
                       o_event_code, o_bit_index, o_frame_last);
                fails++;
            end else begin
                want = event_q.pop_front();
                if (o_event_code !== want.event_code) begin
                    $error("event_code: expected %0d, got %0d", want.event_code, o_event_code);
                    fails++;
                end
                if (o_bit_index !== want.bit_index) begin
                    $error("bit_index: expected %0d, got %0d", want.bit_index, o_bit_index);
                    fails++;
                end
                if (o_frame_last !== want.frame_last) begin
                    $error("frame_last: expected %0d, got %0d", want.frame_last, o_frame_last);
                    fails++;
                end
            end
        end
    end

    // stimulus
    initial begin : stim
        t_cfg c;
        int p;
        int s0;
        int ord_sent;
        int ev0;

        line_cfg.reader_mark_limit = RST_READER_MARK;
        line_cfg.reader_space_limit = RST_READER_SPACE;
        line_cfg.space_timeout = RST_SPACE_TMO;
        line_cfg.one_threshold = RST_ONE_THRESH;
        line_cfg.max_bits = RST_MAX_BITS;
        line_ph = LN_IDLE;
        line_ticks = '0;
        line_bits = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: a full frame with zero, one and trailer
        add_run(1'b0, 6);
        add_run(1'b1, 4);
        add_run(1'b0, 3);
        add_run(1'b1, 99);
        add_hit(1'b0, 1, EV_ZERO, 8'd0, 1'b0);
        add_run(1'b1, 100);
        add_hit(1'b0, 1, EV_ONE, 8'd1, 1'b0);
        add_hit(1'b1, 301, EV_END, 8'd2, 1'b1);
        // mark too long, frame closed at max_bits, reader space too long
        add_reg(REG_READER_MARK, 12'd4);
        add_reg(REG_READER_SPACE, 12'd3);
        add_reg(REG_SPACE_TMO, 12'd2);
        add_reg(REG_ONE_THRESH, 12'd2);
        add_reg(REG_MAX_BITS, 12'd2);
        add_run(1'b0, 5);
        add_hit(1'b1, 1, EV_RERR, 8'd0, 1'b1);
        add_run(1'b0, 4);
        add_run(1'b1, 3);
        add_run(1'b0, 1);
        add_run(1'b1, 1);
        add_hit(1'b0, 1, EV_ZERO, 8'd0, 1'b0);
        add_run(1'b1, 2);
        add_hit(1'b0, 1, EV_ONE, 8'd1, 1'b1);
        add_hit(1'b1, 4, EV_RERR, 8'd0, 1'b1);
        // zero max_bits and zero threshold: the first bit is a one and closes
        add_reg(REG_ONE_THRESH, 12'd0);
        add_reg(REG_MAX_BITS, 12'd0);
        add_run(1'b0, 1);
        add_run(1'b1, 1);
        add_run(1'b0, 1);
        add_run(1'b1, 1);
        add_hit(1'b0, 1, EV_ONE, 8'd0, 1'b1);
        // zero reader space limit: the first space tick is too long
        add_reg(REG_READER_SPACE, 12'd0);
        add_hit(1'b1, 1, EV_RERR, 8'd0, 1'b1);

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                wait_drain();
                write_reg(plan[k].reg_idx, plan[k].value);
            end else begin
                for (int n = 1; n <= plan[k].len; n++)
                    send_sample(plan[k].lvl, plan[k].pinned && n == plan[k].len, plan[k].ev);
            end
        end

        // random phases under changing settings
        p = 0;
        ord_sent = 0;
        ev0 = n_events;
        while (p < 6 || ord_sent < 300 || n_events - ev0 < 48) begin
            s0 = n_sent;
            calm = (p == 4);
            case (p)
                1: begin
                    c = '0;
                    load_settings(c);
                    repeat (3) send_frame(0, 1);
                end
                3: begin
                    // largest limits, short marks and spaces
                    c.reader_mark_limit = '1;
                    c.reader_space_limit = '1;
                    c.space_timeout = '1;
                    c.one_threshold = '1;
                    c.max_bits = '1;
                    load_settings(c);
                    send_run(1'b1, 2);
                    send_run(1'b0, $urandom_range(1, 20));
                    send_run(1'b1, $urandom_range(1, 20));
                    repeat (3) begin
                        send_run(1'b0, $urandom_range(1, 4));
                        send_run(1'b1, $urandom_range(1, 20));
                    end
                    send_run(1'b0, 1);
                end
                5: begin
                    c.reader_mark_limit = 12'd3;
                    c.reader_space_limit = 12'd3;
                    c.space_timeout = 12'd4;
                    c.one_threshold = 12'd2;
                    c.max_bits = 8'd10;
                    load_settings(c);
                    send_frame(12, 12);
                end
                default: begin
                    c.reader_mark_limit = LIMIT_W'($urandom_range(1, 12));
                    c.reader_space_limit = LIMIT_W'($urandom_range(1, 12));
                    c.space_timeout = LIMIT_W'($urandom_range(1, 16));
                    c.one_threshold = LIMIT_W'($urandom_range(0, int'(c.space_timeout) + 1));
                    c.max_bits = BITS_W'($urandom_range(1, 12));
                    load_settings(c);
                    // output held off while samples keep coming
                    if (p == 2)
                        hold_asks++;
                    repeat ($urandom_range(2, 3)) send_frame(0, int'(c.max_bits) + 1);
                    ord_sent += n_sent - s0;
                end
            endcase
            p++;
        end

        calm = 1'b0;
        wait_drain();
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // run limit
    initial begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
